[rtl/core/bpr_pkg.sv]
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types, sizes and codes of the page buffer pool replacement block.
// ----------------------------------------------------------------------------
package bpr_pkg;

    localparam int NUM_FRAMES = 8;
    localparam int PAGE_BITS  = 20;
    localparam int FRAME_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FILL_BITS  = $clog2(NUM_FRAMES + 1);
    localparam int PIN_BITS   = 8;
    localparam int CNT_BITS   = 32;

    localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(NUM_FRAMES - 1);
    localparam logic [FILL_BITS-1:0]  FULL_FILL  = FILL_BITS'(NUM_FRAMES);
    localparam logic [PIN_BITS-1:0]   PIN_MAX    = {PIN_BITS{1'b1}};

    typedef enum logic [2:0] {
        OP_PIN      = 3'd0,
        OP_UNPIN    = 3'd1,
        OP_DIRTY    = 3'd2,
        OP_FORCE    = 3'd3,
        OP_FLUSH    = 3'd4,
        OP_SHUTDOWN = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_FETCH = 2'd1,
        KIND_WB    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // write command into the frame table
    typedef struct packed {
        logic [FRAME_BITS-1:0] idx;
        logic                  pins_we;
        logic [PIN_BITS-1:0]   pins;
        logic                  dirty_we;
        logic                  dirty;
        logic                  install;
        logic [PAGE_BITS-1:0]  page;
        logic                  touch;
        logic [FRAME_BITS-1:0] rank;
        logic                  clear;
    } t_ft_cmd;

    // one frame as read from the table
    typedef struct packed {
        logic                  valid;
        logic [PAGE_BITS-1:0]  page;
        logic                  dirty;
        logic [PIN_BITS-1:0]   pins;
        logic [FRAME_BITS-1:0] rank;
    } t_ft_rd;

    typedef struct packed {
        logic [1:0]            kind;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic [1:0]            status;
        logic [PIN_BITS-1:0]   pins;
        logic [CNT_BITS-1:0]   reads;
        logic [CNT_BITS-1:0]   writes;
        logic                  last;
    } t_result;

    function automatic logic [FRAME_BITS-1:0] frame_inc(input logic [FRAME_BITS-1:0] x);
        return (x == LAST_FRAME) ? '0 : x + 1'b1;
    endfunction

endpackage

[rtl/core/bpr_if.sv]
// ----------------------------------------------------------------------------
// bpr_if
// Handshake channels of the page buffer pool replacement block.
// ----------------------------------------------------------------------------
interface bpr_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    operation;
    logic [bpr_pkg::PAGE_BITS-1:0] page_number;

    modport source (output valid, output operation, output page_number, input ready);
    modport sink   (input valid, input operation, input page_number, output ready);
endinterface

interface bpr_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     result_kind;
    logic [bpr_pkg::PAGE_BITS-1:0]  result_page;
    logic [bpr_pkg::FRAME_BITS-1:0] result_frame;
    logic [1:0]                     status;
    logic [bpr_pkg::PIN_BITS-1:0]   pin_count;
    logic [bpr_pkg::CNT_BITS-1:0]   reads_total;
    logic [bpr_pkg::CNT_BITS-1:0]   writes_total;
    logic                           last;

    modport source (output valid, output result_kind, output result_page,
                    output result_frame, output status, output pin_count,
                    output reads_total, output writes_total, output last, input ready);
    modport sink   (input valid, input result_kind, input result_page,
                    input result_frame, input status, input pin_count,
                    input reads_total, input writes_total, input last, output ready);
endinterface

interface bpr_cfg_if;
    logic valid;
    logic ready;
    logic replacement_mode;

    modport source (output valid, output replacement_mode, input ready);
    modport sink   (input valid, input replacement_mode, output ready);
endinterface

[rtl/core/bpr_frame_table.sv]
// ----------------------------------------------------------------------------
// bpr_frame_table
// Per-frame page, valid, dirty, pin count and recency rank, one read port.
// ----------------------------------------------------------------------------
module bpr_frame_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpr_pkg::t_ft_cmd                i_cmd,
    input  logic [bpr_pkg::FRAME_BITS-1:0]  i_rd_idx,
    output bpr_pkg::t_ft_rd                 o_rd
);
    import bpr_pkg::*;

    logic [PAGE_BITS-1:0]  r_page  [NUM_FRAMES];
    logic                  r_valid [NUM_FRAMES];
    logic                  r_dirty [NUM_FRAMES];
    logic [PIN_BITS-1:0]   r_pins  [NUM_FRAMES];
    logic [FRAME_BITS-1:0] r_rank  [NUM_FRAMES];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (!i_rst_n || i_cmd.clear) begin
                r_page[i]  <= '0;
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
                r_pins[i]  <= '0;
                r_rank[i]  <= FRAME_BITS'(i);
            end else begin
                if (i_cmd.idx == FRAME_BITS'(i)) begin
                    if (i_cmd.pins_we) begin
                        r_pins[i] <= i_cmd.pins;
                    end
                    if (i_cmd.dirty_we) begin
                        r_dirty[i] <= i_cmd.dirty;
                    end
                    if (i_cmd.install) begin
                        r_page[i]  <= i_cmd.page;
                        r_valid[i] <= 1'b1;
                        r_dirty[i] <= 1'b0;
                    end
                end
                // frames more recent than the touched one age by one
                if (i_cmd.touch) begin
                    if (i_cmd.idx == FRAME_BITS'(i)) begin
                        r_rank[i] <= '0;
                    end else if (r_rank[i] < i_cmd.rank) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    assign o_rd.valid = r_valid[i_rd_idx];
    assign o_rd.page  = r_page[i_rd_idx];
    assign o_rd.dirty = r_dirty[i_rd_idx];
    assign o_rd.pins  = r_pins[i_rd_idx];
    assign o_rd.rank  = r_rank[i_rd_idx];

endmodule

[rtl/core/page_buffer_pool_replacement.sv]
// ----------------------------------------------------------------------------
// page_buffer_pool_replacement
// Frame table sequencer: lookup, victim search, write back and fetch requests.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        handshake
//  i_in      in   operation, page_number                         valid/ready
//  o_out     out  kind, page, frame, status, pins, totals, last  valid/ready
//  i_cfg     in   replacement_mode                               valid/ready
//
//  one frame is examined per cycle through the single table read port; a flush
//  holds on a frame that needs write back while o_out stalls
//  i_in.ready is high only while the sequencer is idle; results leave through
//  one output register, so a stalled sink holds the sequencer
//  synchronous active-low reset empties the pool and clears the counters
module page_buffer_pool_replacement (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpr_in_if.sink     i_in,
    bpr_out_if.source  o_out,
    bpr_cfg_if.sink    i_cfg
);
    import bpr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_HIT, S_HIT_DONE, S_MISS, S_FIFO, S_LRU, S_FULL,
        S_NR, S_VWB, S_FETCH, S_PIN_DONE, S_SHUT_CHK, S_FLUSH, S_FL_END
    } t_state;

    t_state                r_state, n_state;
    logic [2:0]            r_op;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_idx, n_idx;
    logic [FRAME_BITS-1:0] r_cnt, n_cnt;
    logic                  r_found, n_found;
    logic [FRAME_BITS-1:0] r_best_rank, n_best_rank;
    logic [FRAME_BITS-1:0] r_best_idx, n_best_idx;
    logic [CNT_BITS-1:0]   r_reads, n_reads;
    logic [CNT_BITS-1:0]   r_writes, n_writes;
    logic [FILL_BITS-1:0]  r_fill, n_fill;
    logic [FRAME_BITS-1:0] r_ptr, n_ptr;
    logic                  r_mode;
    logic                  r_out_valid;
    t_result               r_res, res;
    logic                  emit;
    logic                  slot;
    logic                  take;
    logic                  need_wb;
    t_ft_cmd               cmd;
    t_ft_rd                rd;

    bpr_frame_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rd_idx (r_idx),
        .o_rd     (rd)
    );

    assign slot        = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign take    = (rd.pins == '0) && (!r_found || (rd.rank > r_best_rank));
    assign need_wb = rd.valid && (rd.pins == '0) && rd.dirty;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_found     = r_found;
        n_best_rank = r_best_rank;
        n_best_idx  = r_best_idx;
        n_reads     = r_reads;
        n_writes    = r_writes;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        cmd         = '0;
        cmd.idx     = r_idx;
        emit        = 1'b0;
        res         = '0;
        res.kind    = KIND_DONE;
        res.status  = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_idx = '0;
                    case (i_in.operation) inside
                        OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE: n_state = S_SCAN;
                        OP_FLUSH:                             n_state = S_FLUSH;
                        OP_SHUTDOWN:                          n_state = S_SHUT_CHK;
                        default:                              n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (rd.valid && (rd.page == r_page)) begin
                    n_state = S_HIT;
                end else if (r_idx == LAST_FRAME) begin
                    n_state = (r_op == OP_PIN) ? S_MISS : S_NR;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_HIT: begin
                if (slot) begin
                    emit      = 1'b1;
                    res.page  = r_page;
                    res.frame = r_idx;
                    res.pins  = rd.pins;
                    res.last  = 1'b1;
                    n_state   = S_IDLE;
                    case (r_op)
                        OP_PIN: begin
                            cmd.pins_we = 1'b1;
                            cmd.pins    = (rd.pins == PIN_MAX) ? rd.pins : rd.pins + 1'b1;
                            cmd.touch   = 1'b1;
                            cmd.rank    = rd.rank;
                            res.pins    = cmd.pins;
                        end
                        OP_UNPIN: begin
                            cmd.pins_we = 1'b1;
                            cmd.pins    = (rd.pins == '0) ? rd.pins : rd.pins - 1'b1;
                            res.pins    = cmd.pins;
                        end
                        OP_DIRTY: begin
                            cmd.dirty_we = 1'b1;
                            cmd.dirty    = 1'b1;
                        end
                        default: begin
                            // force: write back first, completion follows
                            res.kind     = KIND_WB;
                            res.page     = rd.page;
                            res.last     = 1'b0;
                            n_writes     = r_writes + 1'b1;
                            cmd.dirty_we = 1'b1;
                            cmd.dirty    = 1'b0;
                            n_state      = S_HIT_DONE;
                        end
                    endcase
                end
            end
            S_HIT_DONE: begin
                if (slot) begin
                    emit      = 1'b1;
                    res.page  = r_page;
                    res.frame = r_idx;
                    res.pins  = rd.pins;
                    res.last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_MISS: begin
                if (r_fill < FULL_FILL) begin
                    n_idx   = r_fill[FRAME_BITS-1:0];
                    n_state = S_VWB;
                end else if (r_mode) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_LRU;
                end else begin
                    n_idx   = r_ptr;
                    n_cnt   = '0;
                    n_state = S_FIFO;
                end
            end
            S_FIFO: begin
                if (rd.pins == '0) begin
                    n_state = S_VWB;
                end else if (r_cnt == LAST_FRAME) begin
                    n_state = S_FULL;
                end else begin
                    n_idx = frame_inc(r_idx);
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LRU: begin
                if (take) begin
                    n_found     = 1'b1;
                    n_best_rank = rd.rank;
                    n_best_idx  = r_idx;
                end
                if (r_idx == LAST_FRAME) begin
                    if (r_found || take) begin
                        n_idx   = take ? r_idx : r_best_idx;
                        n_state = S_VWB;
                    end else begin
                        n_state = S_FULL;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FULL: begin
                if (slot) begin
                    emit       = 1'b1;
                    res.page   = r_page;
                    res.status = ST_FULL;
                    res.last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_NR: begin
                if (slot) begin
                    emit       = 1'b1;
                    res.page   = (r_op == OP_SHUTDOWN) ? '0 : r_page;
                    res.status = ST_MISS;
                    res.last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_VWB: begin
                if (rd.valid && rd.dirty) begin
                    if (slot) begin
                        emit         = 1'b1;
                        res.kind     = KIND_WB;
                        res.page     = rd.page;
                        res.frame    = r_idx;
                        res.pins     = rd.pins;
                        n_writes     = r_writes + 1'b1;
                        cmd.dirty_we = 1'b1;
                        cmd.dirty    = 1'b0;
                        n_state      = S_FETCH;
                    end
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (slot) begin
                    emit        = 1'b1;
                    res.kind    = KIND_FETCH;
                    res.page    = r_page;
                    res.frame   = r_idx;
                    res.pins    = PIN_BITS'(1);
                    n_reads     = r_reads + 1'b1;
                    cmd.install = 1'b1;
                    cmd.page    = r_page;
                    cmd.pins_we = 1'b1;
                    cmd.pins    = PIN_BITS'(1);
                    cmd.touch   = 1'b1;
                    cmd.rank    = rd.rank;
                    n_ptr       = frame_inc(r_ptr);
                    if (r_fill < FULL_FILL) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = S_PIN_DONE;
                end
            end
            S_PIN_DONE: begin
                if (slot) begin
                    emit      = 1'b1;
                    res.page  = r_page;
                    res.frame = r_idx;
                    res.pins  = PIN_BITS'(1);
                    res.last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SHUT_CHK: begin
                if (rd.valid && (rd.pins != '0)) begin
                    n_state = S_NR;
                end else if (r_idx == LAST_FRAME) begin
                    n_idx   = '0;
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FLUSH: begin
                if (!need_wb || slot) begin
                    if (need_wb) begin
                        emit         = 1'b1;
                        res.kind     = KIND_WB;
                        res.page     = rd.page;
                        res.frame    = r_idx;
                        res.pins     = rd.pins;
                        n_writes     = r_writes + 1'b1;
                        cmd.dirty_we = 1'b1;
                        cmd.dirty    = 1'b0;
                    end
                    if (r_idx == LAST_FRAME) begin
                        n_state = S_FL_END;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FL_END: begin
                if (slot) begin
                    emit     = 1'b1;
                    res.last = 1'b1;
                    n_state  = S_IDLE;
                    if (r_op == OP_SHUTDOWN) begin
                        cmd.clear = 1'b1;
                        n_fill    = '0;
                        n_ptr     = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        res.reads  = n_reads;
        res.writes = n_writes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_best_rank <= '0;
            r_best_idx  <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_best_rank <= n_best_rank;
            r_best_idx  <= n_best_idx;
            r_reads     <= n_reads;
            r_writes    <= n_writes;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            if (i_cfg.valid) begin
                r_mode <= i_cfg.replacement_mode;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.operation;
            r_page <= i_in.page_number;
        end
        if (emit) begin
            r_res <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_res.kind;
    assign o_out.result_page  = r_res.page;
    assign o_out.result_frame = r_res.frame;
    assign o_out.status       = r_res.status;
    assign o_out.pin_count    = r_res.pins;
    assign o_out.reads_total  = r_res.reads;
    assign o_out.writes_total = r_res.writes;
    assign o_out.last         = r_res.last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("fill count beyond frame count");

    a_fetch_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.kind == KIND_FETCH)) |->
            ((r_res.pins == PIN_BITS'(1)) && (r_res.status == ST_OK) && !r_res.last))
        else $error("malformed fetch request");

    a_fetch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (res.kind == KIND_FETCH)) |=> (r_reads == $past(r_reads) + 1'b1))
        else $error("fetch issued without read count step");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !emit)
        else $error("result produced while idle");

endmodule

[tb/sv/page_buffer_pool_replacement_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_buffer_pool_replacement_tb
// Drives pin, unpin, dirty, force, flush and shutdown traffic into the frame
// table under both victim policies, predicts every status, fetch and write
// back result in a local copy of the table and compares field by field.
// ----------------------------------------------------------------------------
module page_buffer_pool_replacement_tb;
    import bpr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpr_in_if  in_ch ();
    bpr_out_if out_ch ();
    bpr_cfg_if cfg_ch ();

    page_buffer_pool_replacement u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #6 i_clk = ~i_clk;

    // local copy of the frame table
    logic [PAGE_BITS-1:0]  tbl_page [NUM_FRAMES];
    logic                  tbl_valid [NUM_FRAMES];
    logic                  tbl_dirty [NUM_FRAMES];
    logic [PIN_BITS-1:0]   tbl_pins [NUM_FRAMES];
    logic [FRAME_BITS-1:0] tbl_rank [NUM_FRAMES];
    int unsigned           tbl_fill;
    logic [FRAME_BITS-1:0] tbl_ptr;
    logic [CNT_BITS-1:0]   fetch_cnt;
    logic [CNT_BITS-1:0]   wb_cnt;
    logic                  lru_mode;

    t_result     pending_results [$];
    int          error_count = 0;
    int          result_count = 0;
    int          item_count = 0;
    bit          sink_stalls = 1'b1;
    bit          source_gaps = 1'b1;
    longint      cycle_count = 0;

    function automatic void table_clear();
        for (int i = 0; i < NUM_FRAMES; i++) begin
            tbl_page[i] = '0;
            tbl_valid[i] = 1'b0;
            tbl_dirty[i] = 1'b0;
            tbl_pins[i] = '0;
            tbl_rank[i] = FRAME_BITS'(i);
        end
        tbl_fill = 0;
        tbl_ptr = '0;
    endfunction

    function automatic void push_result(t_kind kind, logic [PAGE_BITS-1:0] page,
                                        logic [FRAME_BITS-1:0] frame, t_status st,
                                        logic [PIN_BITS-1:0] pins);
        t_result r;
        r.kind = kind;
        r.page = page;
        r.frame = frame;
        r.status = st;
        r.pins = pins;
        r.reads = fetch_cnt;
        r.writes = wb_cnt;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void make_recent(int f);
        for (int i = 0; i < NUM_FRAMES; i++)
            if (tbl_rank[i] < tbl_rank[f]) tbl_rank[i]++;
        tbl_rank[f] = '0;
    endfunction

    function automatic int lookup_frame(logic [PAGE_BITS-1:0] page);
        for (int i = 0; i < NUM_FRAMES; i++)
            if (tbl_valid[i] && tbl_page[i] == page) return i;
        return -1;
    endfunction

    function automatic int choose_victim();
        int f;
        if (lru_mode) begin
            for (int r = NUM_FRAMES - 1; r >= 0; r--)
                for (int i = 0; i < NUM_FRAMES; i++)
                    if (tbl_rank[i] == r && tbl_pins[i] == 0) return i;
            return -1;
        end
        for (int i = 0; i < NUM_FRAMES; i++) begin
            f = (int'(tbl_ptr) + i) % NUM_FRAMES;
            if (tbl_pins[f] == 0) return f;
        end
        return -1;
    endfunction

    function automatic void write_back_frame(int f);
        wb_cnt++;
        tbl_dirty[f] = 1'b0;
        push_result(KIND_WB, tbl_page[f], FRAME_BITS'(f), ST_OK, tbl_pins[f]);
    endfunction

    function automatic void flush_frames();
        for (int i = 0; i < NUM_FRAMES; i++)
            if (tbl_valid[i] && tbl_pins[i] == 0 && tbl_dirty[i]) write_back_frame(i);
    endfunction

    // works out the results of one accepted operation
    function automatic void predict_operation(logic [2:0] op, logic [PAGE_BITS-1:0] page);
        int f;
        int before_n;
        bit busy;
        before_n = pending_results.size();
        case (op)
            OP_PIN: begin
                f = lookup_frame(page);
                if (f >= 0) begin
                    if (tbl_pins[f] != PIN_MAX) tbl_pins[f]++;
                    make_recent(f);
                    push_result(KIND_DONE, page, FRAME_BITS'(f), ST_OK, tbl_pins[f]);
                end else begin
                    f = (tbl_fill < NUM_FRAMES) ? int'(tbl_fill) : choose_victim();
                    if (f < 0) begin
                        push_result(KIND_DONE, page, '0, ST_FULL, '0);
                    end else begin
                        if (tbl_valid[f] && tbl_dirty[f]) write_back_frame(f);
                        fetch_cnt++;
                        tbl_page[f] = page;
                        tbl_valid[f] = 1'b1;
                        tbl_dirty[f] = 1'b0;
                        tbl_pins[f] = 8'd1;
                        make_recent(f);
                        tbl_ptr = frame_inc(tbl_ptr);
                        if (tbl_fill < NUM_FRAMES) tbl_fill++;
                        push_result(KIND_FETCH, page, FRAME_BITS'(f), ST_OK, 8'd1);
                        push_result(KIND_DONE, page, FRAME_BITS'(f), ST_OK, 8'd1);
                    end
                end
            end
            OP_UNPIN, OP_DIRTY, OP_FORCE: begin
                f = lookup_frame(page);
                if (f < 0) begin
                    push_result(KIND_DONE, page, '0, ST_MISS, '0);
                end else begin
                    if (op == OP_UNPIN) begin
                        if (tbl_pins[f] != 0) tbl_pins[f]--;
                    end else if (op == OP_DIRTY) begin
                        tbl_dirty[f] = 1'b1;
                    end else begin
                        write_back_frame(f);
                    end
                    push_result(KIND_DONE, page, FRAME_BITS'(f), ST_OK, tbl_pins[f]);
                end
            end
            OP_FLUSH: begin
                flush_frames();
                push_result(KIND_DONE, '0, '0, ST_OK, '0);
            end
            OP_SHUTDOWN: begin
                busy = 1'b0;
                for (int i = 0; i < NUM_FRAMES; i++)
                    if (tbl_valid[i] && tbl_pins[i] != 0) busy = 1'b1;
                if (busy) begin
                    push_result(KIND_DONE, '0, '0, ST_MISS, '0);
                end else begin
                    flush_frames();
                    table_clear();
                    push_result(KIND_DONE, '0, '0, ST_OK, '0);
                end
            end
            default: ;
        endcase
        if (pending_results.size() > before_n)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // source side: one operation per transfer
    task automatic send_operation(logic [2:0] op, logic [PAGE_BITS-1:0] page);
        if (source_gaps && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.page_number <= page;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_operation(op, page);
        item_count++;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        // idle ops (codes 6, 7) and the tail of the sequencer
        repeat (3 * NUM_FRAMES + 10) @(posedge i_clk);
    endtask

    task automatic set_mode(logic mode);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.replacement_mode <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        lru_mode = mode;
        cfg_ch.valid <= 1'b0;
    endtask

    // sink side: random stalls, compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d page=%0h", out_ch.result_kind,
                       out_ch.result_page);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_ch.result_kind !== exp_r.kind) begin
                    $error("result_kind exp %0d got %0d", exp_r.kind, out_ch.result_kind);
                    error_count++;
                end
                if (out_ch.result_page !== exp_r.page) begin
                    $error("result_page exp %0h got %0h", exp_r.page, out_ch.result_page);
                    error_count++;
                end
                if (out_ch.result_frame !== exp_r.frame) begin
                    $error("result_frame exp %0d got %0d", exp_r.frame, out_ch.result_frame);
                    error_count++;
                end
                if (out_ch.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.pin_count !== exp_r.pins) begin
                    $error("pin_count exp %0d got %0d", exp_r.pins, out_ch.pin_count);
                    error_count++;
                end
                if (out_ch.reads_total !== exp_r.reads) begin
                    $error("reads_total exp %0d got %0d", exp_r.reads, out_ch.reads_total);
                    error_count++;
                end
                if (out_ch.writes_total !== exp_r.writes) begin
                    $error("writes_total exp %0d got %0d", exp_r.writes, out_ch.writes_total);
                    error_count++;
                end
                if (out_ch.last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, out_ch.last);
                    error_count++;
                end
            end
        end
        out_ch.ready <= sink_stalls ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // pages drawn from a small working set so hits, misses and evictions mix
    function automatic logic [PAGE_BITS-1:0] pick_page();
        if ($urandom_range(0, 9) == 0) return PAGE_BITS'($urandom);
        return PAGE_BITS'($urandom_range(0, 13)) ^ 20'hA5A50;
    endfunction

    task automatic test_directed();
        send_operation(OP_UNPIN, 20'h00000);     // not resident
        send_operation(OP_PIN, 20'h00000);
        send_operation(OP_PIN, 20'hFFFFF);
        send_operation(OP_PIN, 20'h55555);
        send_operation(OP_PIN, 20'hAAAAA);
        send_operation(OP_DIRTY, 20'hFFFFF);
        send_operation(OP_FORCE, 20'hFFFFF);
        send_operation(OP_DIRTY, 20'h55555);
        send_operation(OP_SHUTDOWN, 20'h0);      // refused, frames pinned
        send_operation(OP_UNPIN, 20'h55555);
        send_operation(OP_UNPIN, 20'h55555);     // saturates at zero
        send_operation(OP_FLUSH, 20'h0);
        send_operation(3'd6, 20'h12345);         // ignored codes
        send_operation(3'd7, 20'h12345);
        for (int i = 0; i < 5; i++) send_operation(OP_PIN, PAGE_BITS'(20'h10 + i));
        send_operation(OP_PIN, 20'h99999);       // every frame pinned
        send_operation(OP_FORCE, 20'h77777);
        send_operation(OP_DIRTY, 20'h77777);
    endtask

    // raise one frame's pin count, then unpin it past zero
    task automatic test_pin_saturation();
        for (int i = 0; i < 3; i++) send_operation(OP_PIN, 20'hFFFFF);
        for (int i = 0; i < 6; i++) send_operation(OP_UNPIN, 20'hFFFFF);
    endtask

    task automatic test_release_all();
        for (int p = 0; p < 14; p++) send_operation(OP_UNPIN, PAGE_BITS'(20'hA5A50 ^ p));
        foreach (tbl_valid[i])
            while (tbl_valid[i] && tbl_pins[i] != 0) send_operation(OP_UNPIN, tbl_page[i]);
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      send_operation(OP_PIN, pick_page());
            else if (r < 70) send_operation(OP_UNPIN, pick_page());
            else if (r < 82) send_operation(OP_DIRTY, pick_page());
            else if (r < 89) send_operation(OP_FORCE, pick_page());
            else if (r < 94) send_operation(OP_FLUSH, PAGE_BITS'($urandom));
            else if (r < 97) send_operation(OP_SHUTDOWN, PAGE_BITS'($urandom));
            else             send_operation(3'($urandom_range(6, 7)), pick_page());
        end
    endtask

    task automatic test_clean_shutdown();
        test_release_all();
        send_operation(OP_DIRTY, tbl_page[0]);
        send_operation(OP_SHUTDOWN, 20'h0);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.page_number = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.replacement_mode = 1'b0;
        out_ch.ready = 1'b0;
        lru_mode = 1'b0;
        fetch_cnt = '0;
        wb_cnt = '0;
        table_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(1'b0);
        test_directed();
        test_pin_saturation();
        test_release_all();
        test_random(35);
        // sender holds off until the pool is quiet
        wait_drained();
        test_clean_shutdown();
        set_mode(1'b1);
        test_directed();
        test_release_all();
        test_random(35);
        test_clean_shutdown();
        set_mode(1'b0);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random(25);
        wait_drained();

        $display("covered %0d operations and %0d results over FIFO and LRU victim choice,",
                 item_count, result_count);
        $display("including pin limits, full pool, flush and shutdown cases");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[page_buffer_pool_replacement.f]
rtl/core/bpr_pkg.sv
rtl/core/bpr_if.sv
rtl/core/bpr_frame_table.sv
rtl/core/page_buffer_pool_replacement.sv
tb/sv/page_buffer_pool_replacement_tb.sv
